[rtl/core/fcp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_pkg
// shared types and constants of the framed command parser
// ----------------------------------------------------------------------------
package fcp_pkg;

   typedef logic [7:0]  octet_type;
   typedef logic [15:0] crc_type;

   // start-of-frame pattern
   localparam octet_type START_FIRST  = 8'hA5;
   localparam octet_type START_SECOND = 8'h5A;

   // crc-16/modbus, reflected form
   localparam crc_type CRC_POLY = 16'hA001;
   localparam crc_type CRC_INIT = 16'hFFFF;

   // result status codes
   localparam logic STATUS_GOOD    = 1'b0;
   localparam logic STATUS_CRC_ERR = 1'b1;

endpackage

[rtl/core/fcp_crc16_byte.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_crc16_byte
// one-byte update of a reflected crc-16, eight bit steps, combinational
// ----------------------------------------------------------------------------
module fcp_crc16_byte (
   input  fcp_pkg::crc_type   crc_in,
   input  fcp_pkg::octet_type data_in,
   output fcp_pkg::crc_type   crc_out
);
   import fcp_pkg::*;

   always_comb begin
      crc_type c;
      c = crc_in ^ {8'h00, data_in};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_out = c;
   end

endmodule

[rtl/core/framed_command_parser_crc16_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_command_parser_crc16_core
// byte-serial parser for a fixed-length command frame with crc-16/modbus check
//
//   channel  | ports                          | direction | moves
//   ---------+--------------------------------+-----------+-----------------------
//   req      | req_valid req_stall req_rx_byte| in        | one received byte
//   rsp      | rsp_valid rsp_stall rsp_*      | out       | one parsed frame
//
// one byte per cycle while the response channel does not stall: a request is held
// in the input register, then the parser state, the byte-wide crc update and the
// frame decode run combinationally and land in the state registers and the result register
// a request never yields more than one response; only the last frame byte does
// reset (synchronous, active high) returns to the hunt for the first start byte
// a stalled response holds the result register; a byte then waiting in the
// input register holds as well and the request channel stalls until it moves
// ----------------------------------------------------------------------------
module framed_command_parser_crc16_core #(
   parameter int FRAME_BYTES = 10
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  fcp_pkg::octet_type req_rx_byte,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_frame_status,
   output fcp_pkg::octet_type rsp_sequence_res,
   output logic               rsp_target_seen,
   output logic signed [15:0] rsp_yaw_delta,
   output logic signed [15:0] rsp_pitch_delta
);
   import fcp_pkg::*;

   // frame layout: two start bytes, payload, little-endian crc at the end
   localparam int CRC_BYTES   = FRAME_BYTES - 2;
   localparam int STORE_DEPTH = FRAME_BYTES - 3;
   localparam int POS_W       = $clog2(FRAME_BYTES + 1);
   localparam int IDX_W       = $clog2(STORE_DEPTH);

   // hunt phases
   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_SECOND  = 2'd1;
   localparam logic [1:0] PH_COLLECT = 2'd2;

   localparam logic [POS_W-1:0] POS_ZERO  = '0;
   localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_FIRST = POS_W'(2);
   localparam logic [POS_W-1:0] POS_CRC   = POS_W'(CRC_BYTES);
   localparam logic [POS_W-1:0] POS_STEND = POS_W'(STORE_DEPTH + 2);
   localparam logic [POS_W-1:0] POS_END   = POS_W'(FRAME_BYTES);

   // input register
   logic      in_valid_ff;
   octet_type in_byte_ff;

   // parser state
   logic [1:0]       phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   crc_type          crc_ff, crc_in;
   octet_type        store_ff [STORE_DEPTH];

   // result register
   logic      rsp_valid_ff;
   logic      status_ff, status_in;
   octet_type seq_ff, seq_in;
   logic      target_ff, target_in;
   logic [15:0] yaw_ff, yaw_in;
   logic [15:0] pitch_ff, pitch_in;

   logic       advance;
   logic       crc_restart;
   crc_type    crc_src;
   crc_type    crc_next;
   logic       store_we;
   logic [IDX_W-1:0] store_idx;
   logic [POS_W-1:0] pos_inc;
   logic       frame_end;
   crc_type    crc_recv;

   // the held byte moves on when the result register is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // a first start byte restarts the crc from its initial value
   assign crc_src = crc_restart ? CRC_INIT : crc_ff;

   fcp_crc16_byte u_crc (
      .crc_in  (crc_src),
      .data_in (in_byte_ff),
      .crc_out (crc_next)
   );

   assign pos_inc   = pos_ff + POS_ONE;
   assign store_idx = IDX_W'(pos_ff - POS_FIRST);
   assign crc_recv  = {in_byte_ff, store_ff[STORE_DEPTH-1]};

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      crc_restart = 1'b0;
      store_we    = 1'b0;
      frame_end   = 1'b0;
      case (phase_ff)
         PH_HUNT: begin
            crc_restart = 1'b1;
            if (in_byte_ff == START_FIRST) begin
               phase_in = PH_SECOND;
               pos_in   = POS_ONE;
               crc_in   = crc_next;
            end
         end
         PH_SECOND: begin
            if (in_byte_ff == START_SECOND) begin
               phase_in = PH_COLLECT;
               pos_in   = POS_FIRST;
               crc_in   = crc_next;
            end else if (in_byte_ff == START_FIRST) begin
               // repeated first start byte: keep waiting, crc over this byte only
               crc_restart = 1'b1;
               pos_in      = POS_ONE;
               crc_in      = crc_next;
            end else begin
               phase_in = PH_HUNT;
               pos_in   = POS_ZERO;
               crc_in   = CRC_INIT;
            end
         end
         PH_COLLECT: begin
            if (pos_ff < POS_CRC) begin
               crc_in = crc_next;
            end
            store_we  = (pos_ff >= POS_FIRST) && (pos_ff < POS_STEND);
            pos_in    = pos_inc;
            frame_end = (pos_inc >= POS_END) || (pos_inc == POS_ZERO);
            if (frame_end) begin
               phase_in = PH_HUNT;
               pos_in   = POS_ZERO;
               crc_in   = CRC_INIT;
            end
         end
         default: begin
            // unused phase: drop the byte and start over
            phase_in = PH_HUNT;
            pos_in   = POS_ZERO;
            crc_in   = CRC_INIT;
         end
      endcase
   end

   // decode of a finished frame; mismatch reports zero fields
   always_comb begin
      logic      good;
      crc_type   crc_check;
      crc_check = (pos_ff < POS_CRC) ? crc_next : crc_ff;
      good      = (crc_recv == crc_check);
      if (good) begin
         status_in = STATUS_GOOD;
         seq_in    = store_ff[0];
         target_in = (store_ff[1] != 8'h00);
         yaw_in    = {store_ff[3], store_ff[2]};
         pitch_in  = {store_ff[5], store_ff[4]};
      end else begin
         status_in = STATUS_CRC_ERR;
         seq_in    = '0;
         target_in = 1'b0;
         yaw_in    = '0;
         pitch_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= POS_ZERO;
         crc_ff   <= CRC_INIT;
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
      end
   end

   // payload bytes, no reset: each entry is written before the frame end reads it
   always_ff @(posedge clock) begin
      if (advance && store_we) begin
         store_ff[store_idx] <= in_byte_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && frame_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && frame_end) begin
         status_ff <= status_in;
         seq_ff    <= seq_in;
         target_ff <= target_in;
         yaw_ff    <= yaw_in;
         pitch_ff  <= pitch_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_sequence_res = seq_ff;
   assign rsp_target_seen  = target_ff;
   assign rsp_yaw_delta    = $signed(yaw_ff);
   assign rsp_pitch_delta  = $signed(pitch_ff);

   // while hunting the crc and position sit at their start values
   a_hunt_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT) |-> (crc_ff == CRC_INIT && pos_ff == POS_ZERO))
      else $error("hunt phase with stale crc or position");

   // waiting for the second start byte always follows exactly one byte
   a_second_pos: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SECOND) |-> (pos_ff == POS_ONE))
      else $error("second start byte wait at wrong position");

   // collection stays inside the frame
   a_collect_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_COLLECT) |-> (pos_ff >= POS_FIRST && pos_ff < POS_END))
      else $error("frame position outside the frame");

   // a finished frame shows up in the result register next cycle
   a_frame_result: assert property (@(posedge clock) disable iff (reset)
      (advance && frame_end) |=> rsp_valid_ff)
      else $error("frame end without a response");

   // stall only when a byte is waiting on a full result register that is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without cause");

endmodule
